### design/rmau_pkg.sv
// ----------------------------------------------------------------------------
// rmau_pkg: shared definitions for the modular arithmetic unit
// Operation codes, default widths and the width of the signed reduce input.
// ----------------------------------------------------------------------------
package rmau_pkg;

  localparam int MOD_BITS_DEF = 31;
  localparam int EXP_BITS_DEF = 63;
  localparam int WIDE_BITS    = 64;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_REDUCE = 3'd0;
  localparam kind_t KIND_ADD    = 3'd1;
  localparam kind_t KIND_SUB    = 3'd2;
  localparam kind_t KIND_MUL    = 3'd3;
  localparam kind_t KIND_DIV    = 3'd4;
  localparam kind_t KIND_POW    = 3'd5;
  localparam kind_t KIND_NEG    = 3'd6;
  localparam kind_t KIND_INV    = 3'd7;

endpackage

### design/rmau_div.sv
// ----------------------------------------------------------------------------
// rmau_div: bit-serial restoring divider
// Divides a 64-bit unsigned numerator by a nonzero divisor, one quotient
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module rmau_div #(
  parameter int MB = rmau_pkg::MOD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rmau_pkg::WIDE_BITS-1:0] numer,
  input  logic [MB-1:0]              denom,
  output logic                       done,
  output logic [rmau_pkg::WIDE_BITS-1:0] quot,
  output logic [MB-1:0]              rem
);
  import rmau_pkg::*;

  localparam int CW = $clog2(WIDE_BITS + 1);

  logic [WIDE_BITS-1:0] nreg;
  logic [MB-1:0]        r;
  logic [MB-1:0]        d;
  logic [CW-1:0]        cnt;
  logic                 running;
  logic [MB:0]          trial;
  logic                 ge;

  // One restoring step: shift in the next numerator bit and try a subtract.
  always_comb begin
    trial = {r, nreg[WIDE_BITS-1]};
    ge    = (trial >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(WIDE_BITS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath registers: the numerator register fills with quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= numer;
      r    <= '0;
      d    <= denom;
    end else if (running) begin
      nreg <= {nreg[WIDE_BITS-2:0], ge};
      r    <= ge ? MB'(trial - {1'b0, d}) : trial[MB-1:0];
    end
  end

  assign quot = nreg;
  assign rem  = r;

endmodule

### design/rmau_mul.sv
// ----------------------------------------------------------------------------
// rmau_mul: bit-serial modular multiplier
// Interleaved multiply and reduce: scans the y operand one bit a cycle,
// most significant bit first, keeping the partial product below m.
// ----------------------------------------------------------------------------
module rmau_mul #(
  parameter int MB = rmau_pkg::MOD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MB-1:0] x,
  input  logic [MB-1:0] y,
  input  logic [MB-1:0] m,
  output logic          done,
  output logic [MB-1:0] prod
);
  import rmau_pkg::*;

  localparam int CW = $clog2(MB + 1);

  logic [MB-1:0] xr;
  logic [MB-1:0] yr;
  logic [MB-1:0] mr;
  logic [MB-1:0] p;
  logic [CW-1:0] cnt;
  logic          running;
  logic [MB:0]   dbl;
  logic [MB:0]   dbl_red;
  logic [MB:0]   sum;
  logic [MB-1:0] p_next;

  // Double, reduce, conditionally add x, reduce again.
  always_comb begin
    dbl     = {p, 1'b0};
    dbl_red = (dbl >= {1'b0, mr}) ? dbl - {1'b0, mr} : dbl;
    sum     = dbl_red + (yr[MB-1] ? {1'b0, xr} : '0);
    p_next  = (sum >= {1'b0, mr}) ? MB'(sum - {1'b0, mr}) : sum[MB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(MB);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x;
      yr <= y;
      mr <= m;
      p  <= '0;
    end else if (running) begin
      yr <= {yr[MB-2:0], 1'b0};
      p  <= p_next;
    end
  end

  assign prod = p;

endmodule

### design/runtime_modulus_arith_unit.sv
// ----------------------------------------------------------------------------
// runtime_modulus_arith_unit: modular arithmetic with a programmable modulus
// Reduce, add, subtract, multiply, divide, power, negate and inverse modulo
// a modulus written through the configuration channel.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its residue appears
// on residue for one cycle with done high, and the receiver must take it
// then. Each request first reduces both operands with the serial divider,
// one pass each. Add, subtract and negate then set the residue directly in
// the dispatch state; reduce adds one more divider pass; multiply adds one
// multiplier pass. Inverse runs one divider pass and one multiplier pass per
// Euclid step, up to about 45 steps; divide adds a final multiply. Power
// takes up to two multiplier passes per exponent bit, up to EXP_BITS bits.
// The divider and the multiplier are each one shared unit, so these passes
// add up per request. A modulus of zero acts as one.
module runtime_modulus_arith_unit #(
  parameter int MOD_BITS = rmau_pkg::MOD_BITS_DEF,
  parameter int EXP_BITS = rmau_pkg::EXP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  rmau_pkg::kind_t                kind,
  input  logic [MOD_BITS-1:0]            first_operand,
  input  logic [MOD_BITS-1:0]            second_operand,
  input  logic [EXP_BITS-1:0]            exponent,
  input  logic signed [rmau_pkg::WIDE_BITS-1:0] wide_value,
  output logic                           done,
  output logic [MOD_BITS-1:0]            residue,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [MOD_BITS-1:0]            cfg_data
);
  import rmau_pkg::*;

  localparam int MB = MOD_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RA   = 4'd1;
  localparam logic [3:0] ST_RB   = 4'd2;
  localparam logic [3:0] ST_DISP = 4'd3;
  localparam logic [3:0] ST_WIDE = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_ICHK = 4'd6;
  localparam logic [3:0] ST_IDIV = 4'd7;
  localparam logic [3:0] ST_IMUL = 4'd8;
  localparam logic [3:0] ST_PCHK = 4'd9;
  localparam logic [3:0] ST_PM1  = 4'd10;
  localparam logic [3:0] ST_PM2  = 4'd11;

  logic [3:0]           state;
  logic [MB-1:0]        modulus;
  logic [MB-1:0]        m;
  kind_t                op;
  logic [MB-1:0]        opb_raw;
  logic [EXP_BITS-1:0]  e;
  logic [WIDE_BITS-1:0] wide;
  logic [MB-1:0]        a;
  logic [MB-1:0]        b;
  logic [MB-1:0]        acc;
  logic [MB-1:0]        base;
  logic [MB-1:0]        ea;
  logic [MB-1:0]        eb;
  logic [MB-1:0]        u;
  logic [MB-1:0]        v;

  logic                 div_start;
  logic [WIDE_BITS-1:0] div_numer;
  logic [MB-1:0]        div_denom;
  logic                 div_done;
  logic [WIDE_BITS-1:0] div_quot;
  logic [MB-1:0]        div_rem;

  logic                 mul_start;
  logic [MB-1:0]        mul_x;
  logic [MB-1:0]        mul_y;
  logic                 mul_done;
  logic [MB-1:0]        mul_prod;

  logic [MB:0]          add_sum;
  logic [MB:0]          sub_sum;
  logic [MB:0]          euc_sum;
  logic                 wide_neg;

  rmau_div #(.MB(MB)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  rmau_mul #(.MB(MB)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (m),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign wide_neg  = wide[WIDE_BITS-1];

  // Euclid steps divide by the current remainder, all other passes by m.
  assign div_denom = (state == ST_IDIV) ? eb : m;

  // Residue sums for add, subtract and the Euclid coefficient update.
  always_comb begin
    add_sum = {1'b0, a} + {1'b0, b};
    sub_sum = {1'b0, a} + {1'b0, MB'(m - b)};
    euc_sum = {1'b0, u} + {1'b0, MB'(m - mul_prod)};
  end

  // Modulus register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MB'(1);
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  // Sequencer: operand reduction, then the chosen operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
      mul_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      mul_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            m         <= (modulus == '0) ? MB'(1) : modulus;
            op        <= kind;
            opb_raw   <= second_operand;
            e         <= exponent;
            wide      <= wide_value;
            div_numer <= WIDE_BITS'(first_operand);
            div_start <= 1'b1;
            state     <= ST_RA;
          end
        end
        ST_RA: begin
          if (div_done) begin
            a         <= div_rem;
            div_numer <= WIDE_BITS'(opb_raw);
            div_start <= 1'b1;
            state     <= ST_RB;
          end
        end
        ST_RB: begin
          if (div_done) begin
            b     <= div_rem;
            state <= ST_DISP;
          end
        end
        ST_DISP: begin
          unique case (op)
            KIND_REDUCE: begin
              div_numer <= wide_neg ? WIDE_BITS'(0) - wide : wide;
              div_start <= 1'b1;
              state     <= ST_WIDE;
            end
            KIND_ADD: begin
              residue <= (add_sum >= {1'b0, m}) ? MB'(add_sum - {1'b0, m})
                                                 : add_sum[MB-1:0];
              done    <= 1'b1;
              state   <= ST_IDLE;
            end
            KIND_SUB: begin
              residue <= (sub_sum >= {1'b0, m}) ? MB'(sub_sum - {1'b0, m})
                                                 : sub_sum[MB-1:0];
              done    <= 1'b1;
              state   <= ST_IDLE;
            end
            KIND_NEG: begin
              residue <= (a == '0) ? '0 : MB'(m - a);
              done    <= 1'b1;
              state   <= ST_IDLE;
            end
            KIND_MUL: begin
              mul_x     <= a;
              mul_y     <= b;
              mul_start <= 1'b1;
              state     <= ST_MUL;
            end
            KIND_DIV, KIND_INV: begin
              ea    <= (op == KIND_DIV) ? b : a;
              eb    <= m;
              u     <= (m == MB'(1)) ? '0 : MB'(1);
              v     <= '0;
              state <= ST_ICHK;
            end
            KIND_POW: begin
              acc   <= (m == MB'(1)) ? '0 : MB'(1);
              base  <= a;
              state <= ST_PCHK;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_WIDE: begin
          if (div_done) begin
            residue <= (wide_neg && div_rem != '0) ? MB'(m - div_rem) : div_rem;
            done    <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            residue <= mul_prod;
            done    <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        ST_ICHK: begin
          // Euclid ends when the divisor reaches zero; u holds the inverse.
          if (eb == '0) begin
            if (op == KIND_DIV) begin
              mul_x     <= a;
              mul_y     <= u;
              mul_start <= 1'b1;
              state     <= ST_MUL;
            end else begin
              residue <= u;
              done    <= 1'b1;
              state   <= ST_IDLE;
            end
          end else begin
            div_numer <= WIDE_BITS'(ea);
            div_start <= 1'b1;
            state     <= ST_IDIV;
          end
        end
        ST_IDIV: begin
          if (div_done) begin
            ea        <= eb;
            eb        <= div_rem;
            mul_x     <= v;
            mul_y     <= div_quot[MB-1:0];
            mul_start <= 1'b1;
            state     <= ST_IMUL;
          end
        end
        ST_IMUL: begin
          // Coefficients are kept modulo m: v takes u - q*v.
          if (mul_done) begin
            u     <= v;
            v     <= (euc_sum >= {1'b0, m}) ? MB'(euc_sum - {1'b0, m})
                                             : euc_sum[MB-1:0];
            state <= ST_ICHK;
          end
        end
        ST_PCHK: begin
          if (e == '0) begin
            residue <= acc;
            done    <= 1'b1;
            state   <= ST_IDLE;
          end else if (e[0]) begin
            mul_x     <= acc;
            mul_y     <= base;
            mul_start <= 1'b1;
            state     <= ST_PM1;
          end else begin
            mul_x     <= base;
            mul_y     <= base;
            mul_start <= 1'b1;
            state     <= ST_PM2;
          end
        end
        ST_PM1: begin
          if (mul_done) begin
            acc       <= mul_prod;
            mul_x     <= base;
            mul_y     <= base;
            mul_start <= 1'b1;
            state     <= ST_PM2;
          end
        end
        ST_PM2: begin
          if (mul_done) begin
            base  <= mul_prod;
            e     <= e >> 1;
            state <= ST_PCHK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result strobe is never held high back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // Every result lies below the effective modulus.
  a_residue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> residue < m)
    else $error("residue not below modulus");

  // An accepted request makes the unit busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy");

  // The shared units are only started while a request is in progress.
  a_unit_start: assert property (@(posedge clk) disable iff (rst)
    (div_start || mul_start) |-> busy)
    else $error("arithmetic unit started while idle");
`endif

endmodule
